>>> src/ism_pkg.sv
// Package for the interval subscription matcher.
// Holds request and result codes, the back-end state type and the queue entry type.
// Depends on nothing.
`timescale 1ns / 1ps
package ism_pkg;
   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_COMMIT = 2'd1,
      REQ_PAIR   = 2'd2,
      REQ_END    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_MATCH   = 2'd1,
      KIND_NOMATCH = 2'd2
   } kind_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_LOOK,
      ST_EMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        slot_ok;
      logic        attr_ok;
      logic [5:0]  sub_slot;
      logic [7:0]  attribute;
      logic [15:0] low_bound;
      logic [15:0] high_bound;
      logic [15:0] pub_value;
   } cmd_type;
endpackage

>>> src/ism_front.sv
// Front end: accepts request transactions, checks slot and attribute range,
// and holds them in a two-entry queue. Depends on ism_pkg.
`timescale 1ns / 1ps
module ism_front #(
   parameter int NUM_SLOTS = 64,
   parameter int NUM_ATTRS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_type,
   input  logic [5:0]       req_sub_slot,
   input  logic [4:0]       req_attribute,
   input  logic [15:0]      req_low_bound,
   input  logic [15:0]      req_high_bound,
   input  logic [15:0]      req_pub_value,
   output logic             q_valid,
   output ism_pkg::cmd_type q_cmd,
   input  logic             q_take
);
   import ism_pkg::*;
   cmd_type    mem_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    cmd;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = mem_ff[rp_ff];

   always_comb begin
      cmd            = '0;
      cmd.req_type   = req_type;
      cmd.slot_ok    = (32'(req_sub_slot) < NUM_SLOTS);
      cmd.attr_ok    = (32'(req_attribute) < NUM_ATTRS);
      cmd.sub_slot   = req_sub_slot;
      cmd.attribute  = 8'(req_attribute);
      cmd.low_bound  = req_low_bound;
      cmd.high_bound = req_high_bound;
      cmd.pub_value  = req_pub_value;
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ (q_take && q_valid);
      cnt_in = cnt_ff + 2'(push) - 2'(q_take && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= cmd;
   end
endmodule

>>> src/ism_back.sv
// Back end: subscription tables and the slot-serial scan and emit sequencer.
// Depends on ism_pkg.
`timescale 1ns / 1ps
module ism_back #(
   parameter int NUM_SLOTS = 64,
   parameter int NUM_ATTRS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  ism_pkg::cmd_type q_cmd,
   output logic             q_take,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [5:0]       rsp_matched_slot,
   output logic [15:0]      rsp_hit_count,
   output logic [6:0]       rsp_total_matches,
   output logic             rsp_last
);
   import ism_pkg::*;
   localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int AW    = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
   localparam int CELLS = NUM_SLOTS * NUM_ATTRS;
   localparam int CW    = $clog2(CELLS);

   logic [15:0] low_mem  [CELLS];
   logic [15:0] high_mem [CELLS];
   logic [NUM_ATTRS-1:0] cmark_mem [NUM_SLOTS];
   logic [15:0] hits_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] valid_ff, mis_ff, crow_ok_ff, hits_ok_ff;

   state_type   st_ff, st_in;
   cmd_type     cur_ff;
   logic [SW:0] idx_ff, idx_in;
   logic [6:0]  tot_ff;
   logic [15:0] rlo_ff, rhi_ff;
   logic        rchk_ff;
   logic [SW-1:0] rslot_ff;
   logic [NUM_ATTRS-1:0] rrow_ff;
   logic [15:0] rhit_ff;
   logic        rhit_ok_ff;
   logic        out_v_ff;
   logic [1:0]  out_kind_ff;
   logic [5:0]  out_slot_ff;
   logic [15:0] out_hits_ff;
   logic [6:0]  out_tot_ff;
   logic        out_last_ff;

   logic          out_free, more, found;
   logic [SW-1:0] s_cur, s_cmd, s_hit, s_nxt, row_addr, hit_addr;
   logic [AW-1:0] a_cmd;
   logic [CW-1:0] rd_addr, wr_addr;
   logic [NUM_ATTRS-1:0] row_in;
   logic [15:0]   cur_hits, bumped;
   logic [NUM_SLOTS-1:0] cand;

   assign s_cmd    = cur_ff.sub_slot[SW-1:0];
   assign a_cmd    = cur_ff.attribute[AW-1:0];
   assign s_cur    = idx_ff[SW-1:0];
   assign rd_addr  = CW'(32'(s_cur) * NUM_ATTRS + 32'(a_cmd));
   assign wr_addr  = CW'(32'(s_cmd) * NUM_ATTRS + 32'(a_cmd));
   assign out_free = !out_v_ff || !rsp_stall;
   assign q_take   = (st_ff == ST_IDLE);
   assign cand     = valid_ff & ~mis_ff;
   assign row_addr = (st_ff == ST_IDLE) ? q_cmd.sub_slot[SW-1:0] : s_cur;
   assign hit_addr = (st_ff == ST_EMIT && out_free) ? s_nxt : s_hit;

   always_comb begin
      row_in = ((valid_ff[s_cmd] || !crow_ok_ff[s_cmd]) ? '0 : rrow_ff)
               | (NUM_ATTRS'(1) << a_cmd);
      cur_hits = rhit_ok_ff ? rhit_ff : 16'd0;
      bumped   = (cur_hits == 16'hFFFF) ? 16'hFFFF : cur_hits + 16'd1;
   end

   // Next matching slot at or after the scan index, and the one after it.
   always_comb begin
      found = 1'b0;
      s_hit = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (cand[i] && (32'(i) >= 32'(idx_ff))) begin
            found = 1'b1;
            s_hit = SW'(i);
         end
      end
      more  = 1'b0;
      s_nxt = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (cand[i] && (32'(i) > 32'(s_hit))) begin
            more  = 1'b1;
            s_nxt = SW'(i);
         end
      end
   end

   always_comb begin
      st_in  = st_ff;
      idx_in = idx_ff;
      unique case (st_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (q_valid) begin
               unique case (req_code_type'(q_cmd.req_type))
                  REQ_PAIR: st_in = q_cmd.attr_ok ? ST_SCAN : ST_DONE;
                  REQ_END:  st_in = ST_LOOK;
                  default:  st_in = ST_CLEAR;
               endcase
            end
         end
         ST_CLEAR: st_in = ST_DONE;
         ST_SCAN: begin
            if (32'(idx_ff) == NUM_SLOTS) st_in = ST_DONE;
            else idx_in = idx_ff + 1'b1;
         end
         ST_LOOK: st_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               if (!found || !more) st_in = ST_IDLE;
               else idx_in = (SW+1)'(s_hit) + 1'b1;
            end
         end
         ST_DONE: if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         idx_ff     <= '0;
         valid_ff   <= '0;
         mis_ff     <= '0;
         crow_ok_ff <= '0;
         hits_ok_ff <= '0;
         out_v_ff   <= 1'b0;
         tot_ff     <= '0;
         rchk_ff    <= 1'b0;
      end else begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
         if (out_v_ff && !rsp_stall) out_v_ff <= 1'b0;
         if (st_ff == ST_IDLE) begin
            tot_ff  <= '0;
            rchk_ff <= 1'b0;
         end
         if (st_ff == ST_CLEAR) begin
            if (cur_ff.req_type == REQ_ADD && cur_ff.slot_ok && cur_ff.attr_ok) begin
               if (valid_ff[s_cmd]) begin
                  valid_ff[s_cmd]   <= 1'b0;
                  mis_ff[s_cmd]     <= 1'b0;
                  hits_ok_ff[s_cmd] <= 1'b0;
               end
               crow_ok_ff[s_cmd] <= 1'b1;
            end
            if (cur_ff.req_type == REQ_COMMIT && cur_ff.slot_ok) begin
               valid_ff[s_cmd] <= 1'b1;
               mis_ff[s_cmd]   <= 1'b0;
            end
         end
         if (st_ff == ST_SCAN) begin
            rchk_ff  <= (32'(idx_ff) < NUM_SLOTS) && valid_ff[s_cur] && crow_ok_ff[s_cur];
            rslot_ff <= s_cur;
            if (rchk_ff && rrow_ff[a_cmd]
                && (cur_ff.pub_value < rlo_ff || cur_ff.pub_value > rhi_ff))
               mis_ff[rslot_ff] <= 1'b1;
         end
         if (st_ff == ST_EMIT && out_free) begin
            out_v_ff    <= 1'b1;
            out_last_ff <= !found || !more;
            if (found) begin
               hits_ok_ff[s_hit] <= 1'b1;
               tot_ff            <= tot_ff + 7'd1;
               out_kind_ff       <= KIND_MATCH;
               out_slot_ff       <= 6'(s_hit);
               out_hits_ff       <= bumped;
               out_tot_ff        <= tot_ff + 7'd1;
            end else begin
               out_kind_ff <= KIND_NOMATCH;
               out_slot_ff <= '0;
               out_hits_ff <= '0;
               out_tot_ff  <= '0;
            end
            if (!found || !more) mis_ff <= '0;
         end
         if (st_ff == ST_DONE && out_free) begin
            out_v_ff    <= 1'b1;
            out_kind_ff <= KIND_ACK;
            out_slot_ff <= '0;
            out_hits_ff <= '0;
            out_tot_ff  <= '0;
            out_last_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && q_valid) cur_ff <= q_cmd;
      if (st_ff == ST_CLEAR && cur_ff.req_type == REQ_ADD && cur_ff.slot_ok
          && cur_ff.attr_ok) begin
         low_mem[wr_addr]   <= cur_ff.low_bound;
         high_mem[wr_addr]  <= cur_ff.high_bound;
         cmark_mem[s_cmd]   <= row_in;
      end
      if (st_ff == ST_EMIT && out_free && found) hits_mem[s_hit] <= bumped;
      rlo_ff     <= low_mem[rd_addr];
      rhi_ff     <= high_mem[rd_addr];
      rrow_ff    <= cmark_mem[row_addr];
      rhit_ff    <= hits_mem[hit_addr];
      rhit_ok_ff <= hits_ok_ff[hit_addr];
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_matched_slot  = out_slot_ff;
   assign rsp_hit_count     = out_hits_ff;
   assign rsp_total_matches = out_tot_ff;
   assign rsp_last          = out_last_ff;
endmodule

>>> src/interval_subscription_matcher.sv
// Top level of the interval subscription matcher: front queue and back-end table engine.
// Depends on ism_pkg, ism_front and ism_back.
//
// Channel   Direction  Ports
// req_      in         req_valid, req_stall, req_type, req_sub_slot, req_attribute,
//                      req_low_bound, req_high_bound, req_pub_value
// rsp_      out        rsp_valid, rsp_stall, rsp_kind, rsp_matched_slot, rsp_hit_count,
//                      rsp_total_matches, rsp_last
//
// Add and commit pass through a clear step and an acknowledge step; a publication pair
// scans the constraint memory one slot per cycle and then acknowledges.
// End publication goes through start-up and counter lookup, then emits one result
// a cycle while the response side is not stalled.
// Reset is synchronous and clears valid bits, mismatch marks and per-slot row and counter
// flags; the constraint marks and counter of a slot whose flag is clear read as zero.
// A stalled response holds the back end in its emit or acknowledge step; the front queue keeps two transactions.
`timescale 1ns / 1ps
module interval_subscription_matcher #(
   parameter int NUM_SLOTS = 64,
   parameter int NUM_ATTRS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [5:0]  req_sub_slot,
   input  logic [4:0]  req_attribute,
   input  logic [15:0] req_low_bound,
   input  logic [15:0] req_high_bound,
   input  logic [15:0] req_pub_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [5:0]  rsp_matched_slot,
   output logic [15:0] rsp_hit_count,
   output logic [6:0]  rsp_total_matches,
   output logic        rsp_last
);
   import ism_pkg::*;
   logic    q_valid, q_take;
   cmd_type q_cmd;

   ism_front #(.NUM_SLOTS(NUM_SLOTS), .NUM_ATTRS(NUM_ATTRS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_sub_slot, .req_attribute,
      .req_low_bound, .req_high_bound, .req_pub_value, .q_valid, .q_cmd, .q_take
   );

   ism_back #(.NUM_SLOTS(NUM_SLOTS), .NUM_ATTRS(NUM_ATTRS)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_take, .rsp_valid, .rsp_stall, .rsp_kind,
      .rsp_matched_slot, .rsp_hit_count, .rsp_total_matches, .rsp_last
   );
endmodule

>>> src/ism_checker.sv
// Port-level checker for the interval subscription matcher, bound to the top level.
// Depends on ism_pkg and interval_subscription_matcher.
`timescale 1ns / 1ps
module ism_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [5:0]  rsp_matched_slot,
   input logic [15:0] rsp_hit_count,
   input logic [6:0]  rsp_total_matches,
   input logic        rsp_last
);
   import ism_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_matched_slot) && $stable(rsp_hit_count)
         && $stable(rsp_total_matches) && $stable(rsp_last))
      else $error("Stalled response changed.");
   a_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_MATCH |-> rsp_last && rsp_total_matches == 7'd0
         && rsp_matched_slot == 6'd0 && rsp_hit_count == 16'd0)
      else $error("Acknowledge must be final with zero fields.");
   a_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_MATCH |-> rsp_total_matches != 7'd0
         && rsp_hit_count != 16'd0)
      else $error("Match result with zero count.");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == KIND_ACK || rsp_kind == KIND_MATCH
         || rsp_kind == KIND_NOMATCH)
      else $error("Unknown result kind.");
endmodule

bind interval_subscription_matcher ism_checker u_ism_checker (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_kind, .rsp_matched_slot, .rsp_hit_count,
   .rsp_total_matches, .rsp_last
);
